// File: rtl/core/buddy_page_allocator_macros.svh
// Assertion shorthands for the buddy page allocator checkers.
// Both sample on the rising edge of clk and are off while arst_n is low.
`ifndef BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("buddy page allocator check failed");

// The consequent must hold in the cycle after the antecedent.
`define BPA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("buddy page allocator check failed");

`endif

// File: rtl/core/bpa_pkg.sv
package bpa_pkg;

	localparam int NUM_PAGES       = 1024;
	localparam int MAX_ORDER_LIMIT = 9;
	localparam int PAGE_SHIFT      = 12;

	localparam int PAGE_IDX_W = $clog2(NUM_PAGES);
	localparam int LINK_W     = PAGE_IDX_W + 1;
	localparam int ADDR_W     = 52;
	localparam int CNT_W      = 11;
	localparam int ORD_W      = 4;
	localparam int STATUS_W   = 3;

	localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(NUM_PAGES);

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic REG_MANAGED_PAGES = 1'b0;
	localparam logic REG_REGION_BASE   = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_ORDER = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NO_MEM    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_ADDR  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_HEAD  = 3'd4;

	typedef struct packed {
		logic             free;
		logic             head;
		logic [ORD_W-1:0] ord;
	} mark_t;

	// Largest order whose block still fits in the region, capped at the limit.
	function automatic logic [ORD_W-1:0] top_order(input logic [CNT_W-1:0] total);
		logic [ORD_W-1:0] m;
		m = '0;
		for (int o = 1; o <= MAX_ORDER_LIMIT; o++) begin
			if ((CNT_W+1)'(total) >= ((CNT_W+1)'(1) << o))
				m = ORD_W'(o);
		end
		return m;
	endfunction

	// Largest aligned block that starts at page i and stays inside the region.
	function automatic logic [ORD_W-1:0] greedy_order(input logic [CNT_W-1:0] i,
		input logic [CNT_W-1:0] total, input logic [ORD_W-1:0] mo);
		logic [ORD_W-1:0] best;
		logic [CNT_W:0]   bp;
		best = '0;
		for (int o = 0; o <= MAX_ORDER_LIMIT; o++) begin
			bp = (CNT_W+1)'(1) << o;
			if (ORD_W'(o) <= mo && (((CNT_W+1)'(i) & (bp - 1'b1)) == '0) &&
			    ((CNT_W+1)'(i) + bp <= (CNT_W+1)'(total)))
				best = ORD_W'(o);
		end
		return best;
	endfunction

endpackage

// File: rtl/core/bpa_addr_alu.sv
module bpa_addr_alu import bpa_pkg::*; (
	input  logic              sub,
	input  logic [ADDR_W-1:0] a,
	input  logic [ADDR_W-1:0] b,
	output logic [ADDR_W-1:0] sum
);

	// Wraps modulo the address width, which both the grant and the offset need.
	assign sum = sub ? (a - b) : (a + b);

endmodule

// File: rtl/core/buddy_page_allocator.sv
// Allocate: search the free lists upward from the requested order, then split down to it.
// Free: check the address and the head mark, merge with free buddies, then push the block.
// One item at a time; memories have separate read and write ports; busy stays high until done.
// done lasts one cycle and cannot be held off; a new item may start in that cycle.
// Reset and every configuration write clear all page marks, then rebuild the free lists
// one initial block at a time; busy is high meanwhile.
module buddy_page_allocator import bpa_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                opcode,
	input  logic [ORD_W-1:0]    block_order,
	input  logic [ADDR_W-1:0]   block_address,
	output logic                done,
	output logic [ADDR_W-1:0]   granted_address,
	output logic [STATUS_W-1:0] status,
	output logic [CNT_W-1:0]    pages_free,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [ADDR_W-1:0]   cfg_data
);

	typedef enum logic [4:0] {
		S_CLEAR, S_GR_A, S_GR_B, S_IDLE, S_DECODE,
		S_AL_SRCH, S_AL_RD, S_AL_UNL, S_AL_SPLIT, S_AL_FIN,
		S_FR_CHK, S_FR_VAL, S_MG_TRY, S_MG_CHK, S_FR_PUSH, S_FR_FIN
	} state_t;

	state_t                  state_q;
	logic [PAGE_IDX_W-1:0]   k_q;
	logic [CNT_W-1:0]        i_q;
	logic [ORD_W-1:0]        best_q;
	logic [ORD_W-1:0]        co_q;
	logic [PAGE_IDX_W-1:0]   idx_q;
	logic [PAGE_IDX_W-1:0]   head_q;
	logic [PAGE_IDX_W-1:0]   bud_q;
	logic                    op_q;
	logic [ORD_W-1:0]        ord_q;
	logic [ADDR_W-1:0]       addr_q;
	logic [ADDR_W-1:0]       off_q;
	logic [LINK_W-1:0]       tops_q [MAX_ORDER_LIMIT+1];
	logic [CNT_W-1:0]        free_q;
	logic [CNT_W-1:0]        managed_q;
	logic [ADDR_W-1:0]       base_q;
	logic                    done_q;
	logic [ADDR_W-1:0]       gaddr_q;
	logic [STATUS_W-1:0]     status_q;
	logic [CNT_W-1:0]        pf_q;

	mark_t                   marks_mem [NUM_PAGES];
	logic [LINK_W-1:0]       next_mem  [NUM_PAGES];
	logic [LINK_W-1:0]       prev_mem  [NUM_PAGES];
	mark_t                   mk_rd_q;
	logic [LINK_W-1:0]       nx_rd_q;
	logic [LINK_W-1:0]       pv_rd_q;

	logic                    mk_we, nx_we, pv_we;
	logic [PAGE_IDX_W-1:0]   mk_waddr, nx_waddr, pv_waddr;
	mark_t                   mk_wdata;
	logic [LINK_W-1:0]       nx_wdata, pv_wdata;
	logic [PAGE_IDX_W-1:0]   mk_raddr, ln_raddr;

	logic [CNT_W-1:0]        total_w;
	logic [ORD_W-1:0]        mo_w;
	logic [ORD_W-1:0]        best_w;
	logic [ADDR_W-1:0]       base_pg;
	logic [ADDR_W-1:0]       idx_addr;
	logic [ORD_W-1:0]        co_m1;
	logic [CNT_W-1:0]        sz_w;
	logic [PAGE_IDX_W-1:0]   up_w;
	logic [PAGE_IDX_W-1:0]   bud_w;
	logic [PAGE_IDX_W-1:0]   off_idx;
	logic                    merge_go;
	logic                    bud_ok;
	logic                    off_bad;
	logic                    alu_sub;
	logic [ADDR_W-1:0]       alu_a, alu_b, alu_sum;

	assign total_w  = (managed_q == '0) ? CNT_W'(1) :
	                  (managed_q > CNT_W'(NUM_PAGES)) ? CNT_W'(NUM_PAGES) : managed_q;
	assign mo_w     = top_order(total_w);
	assign best_w   = greedy_order(i_q, total_w, mo_w);
	assign base_pg  = {base_q[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
	assign idx_addr = {{(ADDR_W-PAGE_IDX_W-PAGE_SHIFT){1'b0}}, idx_q, {PAGE_SHIFT{1'b0}}};
	assign co_m1    = co_q - 1'b1;
	assign sz_w     = CNT_W'(1) << co_q;
	assign up_w     = idx_q + (PAGE_IDX_W'(1) << co_m1);
	assign bud_w    = head_q ^ sz_w[PAGE_IDX_W-1:0];
	assign off_idx  = off_q[PAGE_SHIFT +: PAGE_IDX_W];
	assign off_bad  = (off_q[ADDR_W-1:PAGE_SHIFT+PAGE_IDX_W] != '0) ||
	                  (off_q[PAGE_SHIFT-1:0] != '0) || ({1'b0, off_idx} >= total_w);
	assign merge_go = (co_q < mo_w) && ((({1'b0, head_q}) & (sz_w - 1'b1)) == '0) &&
	                  ({1'b0, bud_w} < total_w);
	assign bud_ok   = mk_rd_q.free && mk_rd_q.head && (mk_rd_q.ord == co_q);

	// The one wide adder: block offset on a free, granted address on an allocate.
	assign alu_sub = (state_q != S_AL_FIN);
	assign alu_a   = (state_q == S_AL_FIN) ? base_pg : addr_q;
	assign alu_b   = (state_q == S_AL_FIN) ? idx_addr : base_pg;

	bpa_addr_alu u_alu (
		.sub (alu_sub),
		.a   (alu_a),
		.b   (alu_b),
		.sum (alu_sum)
	);

	always_comb begin
		mk_we    = 1'b0;
		nx_we    = 1'b0;
		pv_we    = 1'b0;
		mk_waddr = '0;
		nx_waddr = '0;
		pv_waddr = '0;
		mk_wdata = '0;
		nx_wdata = NIL_LINK;
		pv_wdata = NIL_LINK;
		mk_raddr = off_idx;
		ln_raddr = idx_q;
		unique case (state_q)
			S_CLEAR: begin
				mk_we    = 1'b1;
				mk_waddr = k_q;
			end
			S_GR_A: begin
				if (i_q < total_w) begin
					mk_we    = 1'b1;
					mk_waddr = i_q[PAGE_IDX_W-1:0];
					mk_wdata = '{free: 1'b1, head: 1'b1, ord: best_w};
					nx_we    = 1'b1;
					nx_waddr = i_q[PAGE_IDX_W-1:0];
					nx_wdata = tops_q[best_w];
					pv_we    = 1'b1;
					pv_waddr = i_q[PAGE_IDX_W-1:0];
				end
			end
			S_GR_B: begin
				if (tops_q[best_q] != NIL_LINK) begin
					pv_we    = 1'b1;
					pv_waddr = tops_q[best_q][PAGE_IDX_W-1:0];
					pv_wdata = i_q;
				end
			end
			S_AL_UNL: begin
				if (nx_rd_q != NIL_LINK) begin
					pv_we    = 1'b1;
					pv_waddr = nx_rd_q[PAGE_IDX_W-1:0];
				end
			end
			S_AL_SPLIT: begin
				if (co_q > ord_q) begin
					mk_we    = 1'b1;
					mk_waddr = up_w;
					mk_wdata = '{free: 1'b1, head: 1'b1, ord: co_m1};
					nx_we    = 1'b1;
					nx_waddr = up_w;
					pv_we    = 1'b1;
					pv_waddr = up_w;
				end
			end
			S_AL_FIN: begin
				mk_we    = 1'b1;
				mk_waddr = idx_q;
				mk_wdata = '{free: 1'b0, head: 1'b1, ord: ord_q};
			end
			S_MG_TRY: begin
				mk_raddr = bud_w;
				ln_raddr = bud_w;
			end
			S_MG_CHK: begin
				if (bud_ok) begin
					// The higher of the two heads is now inside the merged block.
					mk_we    = 1'b1;
					mk_waddr = (bud_q > head_q) ? bud_q : head_q;
					if (pv_rd_q != NIL_LINK) begin
						nx_we    = 1'b1;
						nx_waddr = pv_rd_q[PAGE_IDX_W-1:0];
						nx_wdata = nx_rd_q;
					end
					if (nx_rd_q != NIL_LINK) begin
						pv_we    = 1'b1;
						pv_waddr = nx_rd_q[PAGE_IDX_W-1:0];
						pv_wdata = pv_rd_q;
					end
				end
			end
			S_FR_PUSH: begin
				mk_we    = 1'b1;
				mk_waddr = head_q;
				mk_wdata = '{free: 1'b1, head: 1'b1, ord: co_q};
				nx_we    = 1'b1;
				nx_waddr = head_q;
				nx_wdata = tops_q[co_q];
				pv_we    = 1'b1;
				pv_waddr = head_q;
			end
			S_FR_FIN: begin
				if (tops_q[co_q] != NIL_LINK) begin
					pv_we    = 1'b1;
					pv_waddr = tops_q[co_q][PAGE_IDX_W-1:0];
					pv_wdata = {1'b0, head_q};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mk_we)
			marks_mem[mk_waddr] <= mk_wdata;
		mk_rd_q <= marks_mem[mk_raddr];
	end

	always_ff @(posedge clk) begin
		if (nx_we)
			next_mem[nx_waddr] <= nx_wdata;
		nx_rd_q <= next_mem[ln_raddr];
	end

	always_ff @(posedge clk) begin
		if (pv_we)
			prev_mem[pv_waddr] <= pv_wdata;
		pv_rd_q <= prev_mem[ln_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			k_q       <= '0;
			i_q       <= '0;
			best_q    <= '0;
			co_q      <= '0;
			idx_q     <= '0;
			head_q    <= '0;
			bud_q     <= '0;
			op_q      <= OP_ALLOC;
			ord_q     <= '0;
			addr_q    <= '0;
			off_q     <= '0;
			for (int n = 0; n <= MAX_ORDER_LIMIT; n++)
				tops_q[n] <= NIL_LINK;
			free_q    <= '0;
			managed_q <= CNT_W'(NUM_PAGES);
			base_q    <= ADDR_W'(1048576);
			done_q    <= 1'b0;
			gaddr_q   <= '0;
			status_q  <= ST_OK;
			pf_q      <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MANAGED_PAGES: managed_q <= cfg_data[CNT_W-1:0];
					REG_REGION_BASE:   base_q    <= cfg_data;
				endcase
				state_q <= S_CLEAR;
				k_q     <= '0;
				i_q     <= '0;
				free_q  <= '0;
				for (int n = 0; n <= MAX_ORDER_LIMIT; n++)
					tops_q[n] <= NIL_LINK;
			end else begin
				unique case (state_q)
					S_CLEAR: begin
						k_q <= k_q + 1'b1;
						if (k_q == PAGE_IDX_W'(NUM_PAGES - 1))
							state_q <= S_GR_A;
					end
					S_GR_A: begin
						if (i_q >= total_w) begin
							state_q <= S_IDLE;
						end else begin
							best_q  <= best_w;
							state_q <= S_GR_B;
						end
					end
					S_GR_B: begin
						tops_q[best_q] <= i_q;
						free_q  <= free_q + (CNT_W'(1) << best_q);
						i_q     <= i_q + (CNT_W'(1) << best_q);
						state_q <= S_GR_A;
					end
					S_IDLE: begin
						if (start) begin
							op_q    <= opcode;
							ord_q   <= block_order;
							addr_q  <= block_address;
							state_q <= S_DECODE;
						end
					end
					S_DECODE: begin
						if (ord_q > mo_w) begin
							done_q   <= 1'b1;
							status_q <= ST_BAD_ORDER;
							gaddr_q  <= '0;
							pf_q     <= free_q;
							state_q  <= S_IDLE;
						end else if (op_q == OP_ALLOC) begin
							co_q    <= ord_q;
							state_q <= S_AL_SRCH;
						end else if (addr_q == '0) begin
							done_q   <= 1'b1;
							status_q <= ST_BAD_ADDR;
							gaddr_q  <= '0;
							pf_q     <= free_q;
							state_q  <= S_IDLE;
						end else begin
							off_q   <= alu_sum;
							state_q <= S_FR_CHK;
						end
					end
					S_AL_SRCH: begin
						if (co_q > mo_w) begin
							done_q   <= 1'b1;
							status_q <= ST_NO_MEM;
							gaddr_q  <= '0;
							pf_q     <= free_q;
							state_q  <= S_IDLE;
						end else if (tops_q[co_q] == NIL_LINK) begin
							co_q <= co_q + 1'b1;
						end else begin
							idx_q   <= tops_q[co_q][PAGE_IDX_W-1:0];
							state_q <= S_AL_RD;
						end
					end
					S_AL_RD: state_q <= S_AL_UNL;
					S_AL_UNL: begin
						tops_q[co_q] <= nx_rd_q;
						state_q <= S_AL_SPLIT;
					end
					S_AL_SPLIT: begin
						// The lists searched below the found order were empty, so each upper half
						// becomes the only entry of its list.
						if (co_q > ord_q) begin
							tops_q[co_m1] <= {1'b0, up_w};
							co_q <= co_m1;
						end else begin
							state_q <= S_AL_FIN;
						end
					end
					S_AL_FIN: begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						gaddr_q  <= alu_sum;
						free_q   <= free_q - (CNT_W'(1) << ord_q);
						pf_q     <= free_q - (CNT_W'(1) << ord_q);
						state_q  <= S_IDLE;
					end
					S_FR_CHK: begin
						if (off_bad) begin
							done_q   <= 1'b1;
							status_q <= ST_BAD_ADDR;
							gaddr_q  <= '0;
							pf_q     <= free_q;
							state_q  <= S_IDLE;
						end else begin
							idx_q   <= off_idx;
							state_q <= S_FR_VAL;
						end
					end
					S_FR_VAL: begin
						if (mk_rd_q.free || !mk_rd_q.head || (mk_rd_q.ord != ord_q)) begin
							done_q   <= 1'b1;
							status_q <= ST_NOT_HEAD;
							gaddr_q  <= '0;
							pf_q     <= free_q;
							state_q  <= S_IDLE;
						end else begin
							head_q  <= idx_q;
							co_q    <= ord_q;
							state_q <= S_MG_TRY;
						end
					end
					S_MG_TRY: begin
						if (merge_go) begin
							bud_q   <= bud_w;
							state_q <= S_MG_CHK;
						end else begin
							state_q <= S_FR_PUSH;
						end
					end
					S_MG_CHK: begin
						if (bud_ok) begin
							if (pv_rd_q == NIL_LINK)
								tops_q[co_q] <= nx_rd_q;
							if (bud_q < head_q)
								head_q <= bud_q;
							co_q    <= co_q + 1'b1;
							state_q <= S_MG_TRY;
						end else begin
							state_q <= S_FR_PUSH;
						end
					end
					S_FR_PUSH: state_q <= S_FR_FIN;
					S_FR_FIN: begin
						tops_q[co_q] <= {1'b0, head_q};
						free_q   <= free_q + sz_w;
						done_q   <= 1'b1;
						status_q <= ST_OK;
						gaddr_q  <= '0;
						pf_q     <= free_q + sz_w;
						state_q  <= S_IDLE;
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	assign busy            = (state_q != S_IDLE);
	assign done            = done_q;
	assign granted_address = gaddr_q;
	assign status          = status_q;
	assign pages_free      = pf_q;

endmodule

// File: rtl/core/bpa_checker.sv
`include "buddy_page_allocator_macros.svh"

module bpa_checker import bpa_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input logic [STATUS_W-1:0] status,
	input logic [ADDR_W-1:0]   granted_address
);

	// An accepted item keeps the block busy until its result is out.
	`BPA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	// The result strobe comes only once the block is ready again.
	`BPA_ASSERT_NOW(a_done_ready, done, !busy)
	`BPA_ASSERT_NEXT(a_done_single, done, !done)
	// Only a successful item may carry a non-zero address.
	`BPA_ASSERT_NOW(a_fail_no_addr, done && (status != ST_OK), granted_address == '0)

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (.*);

// File: sim/buddy_page_allocator_tb.sv
module buddy_page_allocator_tb;
	import bpa_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 40;

	typedef struct {
		logic [ADDR_W-1:0]   addr;
		logic [STATUS_W-1:0] st;
		logic [CNT_W-1:0]    pages;
	} grant_t;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		int unsigned       ord;
	} held_block_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic                opcode = OP_ALLOC;
	logic [ORD_W-1:0]    block_order = '0;
	logic [ADDR_W-1:0]   block_address = '0;
	logic                done;
	logic [ADDR_W-1:0]   granted_address;
	logic [STATUS_W-1:0] status;
	logic [CNT_W-1:0]    pages_free;
	logic                cfg_we = 1'b0;
	logic                cfg_index = REG_MANAGED_PAGES;
	logic [ADDR_W-1:0]   cfg_data = '0;

	buddy_page_allocator DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .block_order(block_order), .block_address(block_address),
		.done(done), .granted_address(granted_address), .status(status),
		.pages_free(pages_free), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Allocator shadow state.
	mark_t       marks [NUM_PAGES];
	int unsigned nxt [NUM_PAGES];
	int unsigned prv [NUM_PAGES];
	int unsigned tops [MAX_ORDER_LIMIT+1];
	int unsigned free_pages;
	logic [CNT_W-1:0]  cfg_pages = CNT_W'(1024);
	logic [ADDR_W-1:0] cfg_base = ADDR_W'(1048576);

	grant_t      pending_grants [$];
	held_block_t held_blocks [$];
	int          errors = 0;
	int          idle_cycles = 0;
	bit          quiet = 1'b0;

	function automatic int unsigned eff_pages();
		if (cfg_pages < 1) return 1;
		if (cfg_pages > NUM_PAGES) return NUM_PAGES;
		return cfg_pages;
	endfunction

	function automatic int unsigned max_ord();
		int unsigned t, m;
		t = eff_pages();
		m = 0;
		while (m < MAX_ORDER_LIMIT && (2 << m) <= t) m++;
		return m;
	endfunction

	function automatic logic [ADDR_W-1:0] base_aligned();
		return {cfg_base[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
	endfunction

	function automatic void unlink_page(int unsigned o, int unsigned p);
		int unsigned pv, nx;
		pv = prv[p];
		nx = nxt[p];
		if (pv != NUM_PAGES) nxt[pv] = nx; else tops[o] = nx;
		if (nx != NUM_PAGES) prv[nx] = pv;
		nxt[p] = NUM_PAGES;
		prv[p] = NUM_PAGES;
	endfunction

	function automatic void push_page(int unsigned o, int unsigned p);
		prv[p] = NUM_PAGES;
		nxt[p] = tops[o];
		if (tops[o] != NUM_PAGES) prv[tops[o]] = p;
		tops[o] = p;
	endfunction

	function automatic void mark_block(int unsigned hd, int unsigned o, bit is_free);
		int unsigned idx;
		for (int unsigned j = 0; j < (1 << o); j++) begin
			idx = hd + j;
			if (idx >= NUM_PAGES) break;
			marks[idx].free = is_free;
			marks[idx].head = (j == 0);
			marks[idx].ord = (j == 0) ? ORD_W'(o) : '0;
			nxt[idx] = NUM_PAGES;
			prv[idx] = NUM_PAGES;
		end
	endfunction

	function automatic void rebuild_lists();
		int unsigned total, i, mo, best;
		total = eff_pages();
		mo = max_ord();
		for (int k = 0; k < NUM_PAGES; k++) begin
			marks[k] = '0;
			nxt[k] = NUM_PAGES;
			prv[k] = NUM_PAGES;
		end
		for (int k = 0; k <= MAX_ORDER_LIMIT; k++) tops[k] = NUM_PAGES;
		free_pages = 0;
		i = 0;
		while (i < total) begin
			best = 0;
			for (int o = mo; o >= 0; o--) begin
				if ((i & ((1 << o) - 1)) == 0 && i + (1 << o) <= total) begin
					best = o;
					break;
				end
			end
			mark_block(i, best, 1'b1);
			push_page(best, i);
			free_pages += 1 << best;
			i += 1 << best;
		end
	endfunction

	function automatic logic [STATUS_W-1:0] take_block(int unsigned ord,
		output logic [ADDR_W-1:0] addr);
		int unsigned mo, co, idx, up;
		mo = max_ord();
		co = ord;
		addr = '0;
		if (ord > mo) return ST_BAD_ORDER;
		while (co <= mo && tops[co] == NUM_PAGES) co++;
		if (co > mo) return ST_NO_MEM;
		idx = tops[co];
		unlink_page(co, idx);
		while (co > ord) begin
			co--;
			up = idx + (1 << co);
			mark_block(up, co, 1'b1);
			push_page(co, up);
			mark_block(idx, co, 1'b1);
		end
		mark_block(idx, ord, 1'b0);
		free_pages -= 1 << ord;
		addr = base_aligned() + (ADDR_W'(idx) << PAGE_SHIFT);
		return ST_OK;
	endfunction

	function automatic logic [STATUS_W-1:0] return_block(int unsigned ord,
		logic [ADDR_W-1:0] address);
		int unsigned mo, co, total, idx, hd, b;
		logic [ADDR_W-1:0] off;
		mark_t m;
		mo = max_ord();
		total = eff_pages();
		co = ord;
		if (ord > mo) return ST_BAD_ORDER;
		if (address == '0) return ST_BAD_ADDR;
		off = address - base_aligned();
		if (64'(off) >= (64'(total) << PAGE_SHIFT) || off[PAGE_SHIFT-1:0] != '0)
			return ST_BAD_ADDR;
		idx = 32'(off >> PAGE_SHIFT);
		m = marks[idx];
		if (m.free || !m.head || m.ord != ord) return ST_NOT_HEAD;
		hd = idx;
		while (co < mo) begin
			if ((hd & ((1 << co) - 1)) != 0) break;
			b = hd ^ (1 << co);
			if (b >= total) break;
			m = marks[b];
			if (!m.free || !m.head || m.ord != co) break;
			unlink_page(co, b);
			if (b < hd) hd = b;
			co++;
		end
		mark_block(hd, co, 1'b1);
		push_page(co, hd);
		free_pages += 1 << co;
		return ST_OK;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h, expected %0h", what, got, want);
		errors++;
	endtask

	// Result checker and watchdog.
	always @(posedge clk) begin
		grant_t g;
		if (arst_n && done) begin
			if (pending_grants.size() == 0) begin
				report_mismatch("unexpected result", status, 0);
			end else begin
				g = pending_grants.pop_front();
				if (granted_address !== g.addr)
					report_mismatch("granted_address", granted_address, g.addr);
				if (status !== g.st) report_mismatch("status", status, g.st);
				if (pages_free !== g.pages) report_mismatch("pages_free", pages_free, g.pages);
			end
		end
		if (done || (start && !busy)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_item(logic op, int unsigned ord, logic [ADDR_W-1:0] addr);
		grant_t g;
		held_block_t hb;
		if (!quiet && $urandom_range(0, 99) < 7) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		block_order <= ORD_W'(ord);
		block_address <= addr;
		@(posedge clk);
		while (busy) @(posedge clk);
		g.addr = '0;
		if (op == OP_ALLOC) begin
			g.st = take_block(ord, g.addr);
			if (g.st == ST_OK) begin
				hb.addr = g.addr;
				hb.ord = ord;
				held_blocks.push_back(hb);
			end
		end else begin
			g.st = return_block(ord, addr);
		end
		g.pages = CNT_W'(free_pages);
		pending_grants.push_back(g);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_grants.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [ADDR_W-1:0] value);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		// Let any rebuild still running finish before the next write.
		while (busy) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MANAGED_PAGES) cfg_pages = value[CNT_W-1:0];
		else cfg_base = value;
		rebuild_lists();
		held_blocks.delete();
		// Give the rebuild time to raise busy before the next item is offered.
		repeat (2) @(posedge clk);
	endtask

	task automatic free_held(int unsigned pick);
		held_block_t hb;
		hb = held_blocks[pick];
		held_blocks.delete(pick);
		send_item(OP_FREE, hb.ord, hb.addr);
	endtask

	task automatic test_directed_default();
		send_item(OP_ALLOC, 0, '0);
		send_item(OP_ALLOC, 9, '1);
		send_item(OP_ALLOC, 10, '0);
		send_item(OP_ALLOC, 15, '0);
		send_item(OP_FREE, 15, base_aligned());
		send_item(OP_FREE, 0, '0);
		send_item(OP_FREE, 0, base_aligned() + 1);
		send_item(OP_FREE, 0, base_aligned() + (ADDR_W'(1024) << PAGE_SHIFT));
		send_item(OP_FREE, 0, base_aligned() - 4096);
		send_item(OP_FREE, 3, base_aligned());
		// Second page of the first block is not a head.
		send_item(OP_FREE, 0, base_aligned() + 4096);
		free_held(0);
		send_item(OP_FREE, 0, base_aligned());
		free_held(0);
		send_item(OP_FREE, 9, '1);
	endtask

	task automatic test_tiny_region();
		write_reg(REG_MANAGED_PAGES, '0);
		write_reg(REG_REGION_BASE, '1);
		send_item(OP_ALLOC, 0, '0);
		send_item(OP_ALLOC, 0, '0);
		send_item(OP_ALLOC, 1, '0);
		send_item(OP_FREE, 1, base_aligned());
		send_item(OP_FREE, 0, base_aligned() + 4096);
		free_held(0);
		send_item(OP_FREE, 0, base_aligned());
	endtask

	task automatic test_random(int n);
		int unsigned r, ord, pg;
		logic [ADDR_W-1:0] a;
		for (int k = 0; k < n; k++) begin
			quiet = (k >= n / 3 && k < n / 3 + n / 5);
			r = $urandom_range(0, 99);
			if (r < 45 || (r < 75 && held_blocks.size() == 0)) begin
				ord = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
					: $urandom_range(0, 3);
				a = ADDR_W'({$urandom, $urandom});
				send_item(OP_ALLOC, ord, a);
			end else if (r < 80 && held_blocks.size() != 0) begin
				free_held($urandom_range(0, held_blocks.size() - 1));
			end else begin
				ord = $urandom_range(0, 15);
				pg = $urandom_range(0, 1100);
				case ($urandom_range(0, 3))
					0: a = ADDR_W'({$urandom, $urandom});
					1: a = base_aligned() + (ADDR_W'(pg) << PAGE_SHIFT);
					2: a = base_aligned() + (ADDR_W'(pg) << PAGE_SHIFT) + $urandom_range(1, 4095);
					default: a = '0;
				endcase
				send_item(OP_FREE, ord, a);
			end
		end
		quiet = 1'b0;
	endtask

	task automatic test_hold_off();
		// The sender waits for every outstanding result before going on.
		for (int k = 0; k < 10; k++) begin
			send_item(OP_ALLOC, $urandom_range(0, 2), '0);
			drain_results();
		end
	endtask

	task automatic test_config_sweep();
		write_reg(REG_MANAGED_PAGES, CNT_W'(1023));
		write_reg(REG_REGION_BASE, ADDR_W'(4096));
		test_random(200);
		write_reg(REG_MANAGED_PAGES, {{(ADDR_W-CNT_W){1'b1}}, CNT_W'(2047)});
		test_random(150);
		write_reg(REG_MANAGED_PAGES, ADDR_W'($urandom_range(2, 40)));
		write_reg(REG_REGION_BASE, ADDR_W'({$urandom, $urandom}));
		test_random(150);
		write_reg(REG_MANAGED_PAGES, ADDR_W'(1));
		test_random(30);
		write_reg(REG_MANAGED_PAGES, ADDR_W'($urandom_range(100, 1024)));
		test_random(150);
	endtask

	initial begin
		rebuild_lists();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_default();
		test_random(300);
		test_hold_off();
		test_tiny_region();
		test_config_sweep();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

endmodule
